// File: rtl/tpmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmq_pkg
// Constants, storage entry types and helpers for the tree path minimum unit.
// ----------------------------------------------------------------------------
package tpmq_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 12;

  // fixed field widths
  localparam int FIELD_W  = 11;
  localparam int OP_W     = 2;
  localparam int WEIGHT_W = 32;

  localparam int NODE_W  = $clog2(MAX_NODES + 1);
  localparam int LVL_W   = $clog2(LIFT_LEVELS);
  localparam int TIME_W  = NODE_W + 1;
  localparam int SP_W    = $clog2(MAX_NODES + 2);
  localparam int CMP_W   = (FIELD_W > NODE_W + 1) ? FIELD_W : NODE_W + 1;
  localparam int NODE_DEPTH = MAX_NODES + 1;
  localparam int LIFT_DEPTH = (MAX_NODES + 1) << LVL_W;
  localparam int LIFT_AW    = NODE_W + LVL_W;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_NONE = 32'sh7FFF_FFFF;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic              has_parent;
    logic [NODE_W-1:0] first_child;
  } link_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]          next_sib;
  } edge_t;

  typedef struct packed {
    logic              in_tree;
    logic [TIME_W-1:0] entry;
  } node_t;

  typedef struct packed {
    logic [NODE_W-1:0]          anc;
    logic signed [WEIGHT_W-1:0] minw;
  } lift_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] cursor;
  } stack_t;

  function automatic logic signed [WEIGHT_W-1:0] wmin(
      input logic signed [WEIGHT_W-1:0] x, input logic signed [WEIGHT_W-1:0] y);
    return (x < y) ? x : y;
  endfunction

  // a is an ancestor of (or equal to) b
  function automatic logic is_anc(input logic [TIME_W-1:0] a_in, input logic [TIME_W-1:0] a_out,
                                  input logic [TIME_W-1:0] b_in, input logic [TIME_W-1:0] b_out);
    return (a_in <= b_in) && (a_out >= b_out);
  endfunction

endpackage

// File: rtl/tpmq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tpmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];  // old data on a same-address write
  end

endmodule

// File: rtl/tree_path_min_edge_query_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_path_min_edge_query_unit
// Weighted tree loader, depth-first table build and path minimum query
// using binary lifting tables held in block RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid / in_stall    | opcode, node_a, node_b, edge_weight
//  out      | out_valid / out_stall  | path_minimum (query items only)
//  cfg      | cfg_wr_en              | cfg_wr_data (node_count)
//
// Add edge: link RAM reads of node_a (in idle) and node_b, then writes of
//   node_a and of node_b together with the edge entry.
// Build: a sweep over all MAX_NODES+1 entries clearing the in-tree marks,
//   then per reached node its LIFT_LEVELS lifting rows, written one at a
//   time through the lifting RAM's single write port, plus walk and pop.
// Query: two climbs, one from each endpoint; each level needs a lifting
//   read then a time read of the node it yields.
// After reset a clearing pass of all MAX_NODES+1 entries holds in_stall high.
// An input item is taken only in idle; a finished result sits in the output
//   register while the next item is accepted.
// ----------------------------------------------------------------------------
module tree_path_min_edge_query_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [tpmq_pkg::FIELD_W-1:0]          cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [tpmq_pkg::OP_W-1:0]             opcode,
  input  logic [tpmq_pkg::FIELD_W-1:0]          node_a,
  input  logic [tpmq_pkg::FIELD_W-1:0]          node_b,
  input  logic signed [tpmq_pkg::WEIGHT_W-1:0]  edge_weight,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tpmq_pkg::WEIGHT_W-1:0]  path_minimum
);

  import tpmq_pkg::*;

  // state codes
  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_ADD_RB = 5'd2;
  localparam logic [4:0] S_ADD_WA = 5'd3;
  localparam logic [4:0] S_ADD_WB = 5'd4;
  localparam logic [4:0] S_ROOT   = 5'd5;
  localparam logic [4:0] S_ENT0   = 5'd6;
  localparam logic [4:0] S_ENTK   = 5'd7;
  localparam logic [4:0] S_W_RD   = 5'd8;
  localparam logic [4:0] S_W_DEC  = 5'd9;
  localparam logic [4:0] S_POP    = 5'd10;
  localparam logic [4:0] S_POP_RD = 5'd11;
  localparam logic [4:0] S_Q_TA   = 5'd12;
  localparam logic [4:0] S_Q_TB   = 5'd13;
  localparam logic [4:0] S_Q_RA   = 5'd14;
  localparam logic [4:0] S_Q_RT   = 5'd15;
  localparam logic [4:0] S_Q_CMP  = 5'd16;
  localparam logic [4:0] S_Q_FA   = 5'd17;
  localparam logic [4:0] S_Q_FB   = 5'd18;
  localparam logic [4:0] S_Q_DONE = 5'd19;

  localparam logic [LVL_W-1:0]  LVL_TOP  = LVL_W'(LIFT_LEVELS - 1);
  localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(MAX_NODES);
  localparam logic [NODE_W-1:0] ROOT     = NODE_W'(1);

  logic [4:0]          state;
  logic [FIELD_W-1:0]  node_count;
  logic [NODE_W-1:0]   clr_addr;
  logic                clr_build;

  // add / query operands
  logic [NODE_W-1:0]          na, nb;
  logic signed [WEIGHT_W-1:0] add_w;
  logic [NODE_W-1:0]          fc_a, fc_b;
  logic                       hp_b;
  logic [TIME_W-1:0]          ta_in, ta_out, tb_in, tb_out;
  logic                       in_a;
  logic                       pass;
  logic [NODE_W-1:0]          up;
  logic signed [WEIGHT_W-1:0] upw, res;

  // walk
  logic [TIME_W-1:0]          time_count;
  logic [SP_W-1:0]            sp;
  logic [NODE_W-1:0]          top_v, top_c;
  logic [NODE_W-1:0]          ev, ep;
  logic signed [WEIGHT_W-1:0] ew;
  lift_t                      cur;
  logic [LVL_W-1:0]           lvl;

  // RAM ports
  logic                link_we, edge_we, node_we, exit_we, lift_we, stack_we;
  logic [NODE_W-1:0]   link_waddr, link_raddr, edge_waddr, edge_raddr;
  logic [NODE_W-1:0]   node_waddr, node_raddr, exit_waddr, exit_raddr;
  logic [NODE_W-1:0]   stack_waddr, stack_raddr;
  logic [LIFT_AW-1:0]  lift_waddr, lift_raddr;
  link_t               link_wdata, link_rd;
  edge_t               edge_wdata, edge_rd;
  node_t               node_wdata, node_rd;
  logic [TIME_W-1:0]   exit_wdata, exit_rd;
  lift_t               lift_wdata, lift_ram_rd, lift_rd, lift_nxt, lift_fwd;
  stack_t              stack_wdata, stack_rd;
  logic                lift_fwd_hit;

  logic                in_fire, out_free, cand_new;
  logic [CMP_W-1:0]    active;
  logic                a_ok, b_ok, c_walk;
  logic [SP_W-1:0]     sp_m1, sp_m2;

  assign active = (CMP_W'(node_count) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES)
                                                           : CMP_W'(node_count);
  assign a_ok = (node_a != '0) && (CMP_W'(node_a) <= active);
  assign b_ok = (node_b != '0) && (CMP_W'(node_b) <= active);

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign sp_m1  = sp - SP_W'(1);
  assign sp_m2  = sp - SP_W'(2);
  assign c_walk = (top_c != '0) && (top_c <= NODE_MAX) && (sp <= SP_W'(MAX_NODES));

  // lifting RAM reads the row it is writing while the root fills its own rows
  assign lift_rd  = lift_fwd_hit ? lift_fwd : lift_ram_rd;
  assign lift_nxt = '{anc: lift_rd.anc, minw: wmin(cur.minw, lift_rd.minw)};
  assign cand_new = !is_anc(node_rd.entry, exit_rd, tb_in, tb_out);

  tpmq_ram #(.WIDTH($bits(link_t)), .DEPTH(NODE_DEPTH)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rd));

  tpmq_ram #(.WIDTH($bits(edge_t)), .DEPTH(NODE_DEPTH)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rd));

  tpmq_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rd));

  tpmq_ram #(.WIDTH(TIME_W), .DEPTH(NODE_DEPTH)) u_exit_ram (
    .clk(clk), .we(exit_we), .waddr(exit_waddr), .wdata(exit_wdata),
    .raddr(exit_raddr), .rdata(exit_rd));

  tpmq_ram #(.WIDTH($bits(lift_t)), .DEPTH(LIFT_DEPTH)) u_lift_ram (
    .clk(clk), .we(lift_we), .waddr(lift_waddr), .wdata(lift_wdata),
    .raddr(lift_raddr), .rdata(lift_ram_rd));

  tpmq_ram #(.WIDTH($bits(stack_t)), .DEPTH(NODE_DEPTH)) u_stack_ram (
    .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
    .raddr(stack_raddr), .rdata(stack_rd));

  // RAM port control
  always_comb begin
    link_we = 1'b0;  link_waddr = '0;  link_wdata = '0;  link_raddr = '0;
    edge_we = 1'b0;  edge_waddr = '0;  edge_wdata = '0;  edge_raddr = '0;
    node_we = 1'b0;  node_waddr = '0;  node_wdata = '0;  node_raddr = '0;
    exit_we = 1'b0;  exit_waddr = '0;  exit_wdata = '0;  exit_raddr = '0;
    lift_we = 1'b0;  lift_waddr = '0;  lift_wdata = '0;  lift_raddr = '0;
    stack_we = 1'b0; stack_waddr = '0; stack_wdata = '0; stack_raddr = '0;
    case (state)
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = clr_addr;
        link_we    = !clr_build;
        link_waddr = clr_addr;
        link_raddr = ROOT;
      end
      S_IDLE: begin
        link_raddr = NODE_W'(node_a);
        node_raddr = NODE_W'(node_a);
        exit_raddr = NODE_W'(node_a);
      end
      S_ADD_RB: begin
        link_raddr = nb;
      end
      S_ADD_WA: begin
        link_we    = 1'b1;
        link_waddr = na;
        link_wdata = '{has_parent: 1'b1, first_child: fc_a};
      end
      S_ADD_WB: begin
        link_we    = 1'b1;
        link_waddr = nb;
        link_wdata = '{has_parent: hp_b, first_child: na};
        edge_we    = 1'b1;
        edge_waddr = na;
        edge_wdata = '{weight: add_w, next_sib: fc_b};
      end
      S_ENT0: begin
        node_we    = 1'b1;
        node_waddr = ev;
        node_wdata = '{in_tree: 1'b1, entry: time_count};
        lift_we    = 1'b1;
        lift_waddr = {ev, LVL_W'(0)};
        lift_wdata = '{anc: ep, minw: ew};
        lift_raddr = {ep, LVL_W'(0)};
      end
      S_ENTK: begin
        lift_we    = 1'b1;
        lift_waddr = {ev, lvl};
        lift_wdata = lift_nxt;
        lift_raddr = {lift_nxt.anc, lvl};
      end
      S_W_RD: begin
        node_raddr = top_c;
        link_raddr = top_c;
        edge_raddr = top_c;
      end
      S_W_DEC: begin
        stack_we    = !node_rd.in_tree;
        stack_waddr = sp_m1[NODE_W-1:0];
        stack_wdata = '{node: top_v, cursor: edge_rd.next_sib};
      end
      S_POP: begin
        exit_we     = 1'b1;
        exit_waddr  = top_v;
        exit_wdata  = time_count;
        stack_raddr = sp_m2[NODE_W-1:0];
      end
      S_Q_TA: begin
        node_raddr = nb;
        exit_raddr = nb;
      end
      S_Q_RA: begin
        lift_raddr = {na, lvl};
      end
      S_Q_RT: begin
        node_raddr = lift_rd.anc;
        exit_raddr = lift_rd.anc;
      end
      S_Q_FA: begin
        lift_raddr = {na, LVL_W'(0)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lift_fwd_hit <= 1'b0;
    end else begin
      lift_fwd_hit <= lift_we && (lift_waddr == lift_raddr);
    end
    lift_fwd <= lift_wdata;
  end

  always_ff @(posedge clk) begin
    if (cfg_wr_en) begin
      node_count <= cfg_wr_data;
    end
    if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    case (state)
      S_CLR: begin
        clr_addr <= clr_addr + NODE_W'(1);
        if (clr_addr == NODE_MAX) begin
          time_count <= '0;
          if (clr_build && node_count != '0) begin
            state <= S_ROOT;
          end else begin
            state <= S_IDLE;
          end
        end
      end
      S_IDLE: begin
        na    <= NODE_W'(node_a);
        nb    <= NODE_W'(node_b);
        add_w <= edge_weight;
        res   <= WEIGHT_NONE;
        pass  <= 1'b0;
        if (in_fire) begin
          case (opcode)
            OP_ADD: begin
              if (a_ok && b_ok && NODE_W'(node_a) != ROOT && node_a != node_b) begin
                state <= S_ADD_RB;
              end
            end
            OP_BUILD: begin
              clr_addr  <= '0;
              clr_build <= 1'b1;
              state     <= S_CLR;
            end
            OP_QUERY: begin
              state <= (a_ok && b_ok) ? S_Q_TA : S_Q_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD_RB: begin
        fc_a  <= link_rd.first_child;
        state <= link_rd.has_parent ? S_IDLE : S_ADD_WA;
      end
      S_ADD_WA: begin
        hp_b  <= link_rd.has_parent;
        fc_b  <= link_rd.first_child;
        state <= S_ADD_WB;
      end
      S_ADD_WB: begin
        state <= S_IDLE;
      end
      S_ROOT: begin
        top_v <= ROOT;
        top_c <= link_rd.first_child;
        sp    <= SP_W'(1);
        ev    <= ROOT;
        ep    <= ROOT;
        ew    <= WEIGHT_NONE;
        state <= S_ENT0;
      end
      S_ENT0: begin
        time_count <= time_count + TIME_W'(1);
        cur        <= '{anc: ep, minw: ew};
        lvl        <= LVL_W'(1);
        state      <= S_ENTK;
      end
      S_ENTK: begin
        cur <= lift_nxt;
        if (lvl == LVL_TOP) begin
          state <= S_W_RD;
        end else begin
          lvl <= lvl + LVL_W'(1);
        end
      end
      S_W_RD: begin
        state <= c_walk ? S_W_DEC : S_POP;
      end
      S_W_DEC: begin
        if (!node_rd.in_tree) begin
          ev    <= top_c;
          ep    <= top_v;
          ew    <= edge_rd.weight;
          top_v <= top_c;
          top_c <= link_rd.first_child;
          sp    <= sp + SP_W'(1);
          state <= S_ENT0;
        end else begin
          state <= S_POP;
        end
      end
      S_POP: begin
        time_count <= time_count + TIME_W'(1);
        sp         <= sp_m1;
        state      <= (sp == SP_W'(1)) ? S_IDLE : S_POP_RD;
      end
      S_POP_RD: begin
        top_v <= stack_rd.node;
        top_c <= stack_rd.cursor;
        state <= S_W_RD;
      end
      S_Q_TA: begin
        ta_in  <= node_rd.entry;
        ta_out <= exit_rd;
        in_a   <= node_rd.in_tree;
        state  <= S_Q_TB;
      end
      S_Q_TB: begin
        tb_in  <= node_rd.entry;
        tb_out <= exit_rd;
        lvl    <= LVL_TOP;
        state  <= (in_a && node_rd.in_tree) ? S_Q_RA : S_Q_DONE;
      end
      S_Q_RA: begin
        state <= S_Q_RT;
      end
      S_Q_RT: begin
        up    <= lift_rd.anc;
        upw   <= lift_rd.minw;
        state <= S_Q_CMP;
      end
      S_Q_CMP: begin
        if (cand_new) begin
          res    <= wmin(res, upw);
          na     <= up;
          ta_in  <= node_rd.entry;
          ta_out <= exit_rd;
        end
        if (lvl == '0) begin
          state <= S_Q_FA;
        end else begin
          lvl   <= lvl - LVL_W'(1);
          state <= S_Q_RA;
        end
      end
      S_Q_FA: begin
        state <= S_Q_FB;
      end
      S_Q_FB: begin
        if (!is_anc(ta_in, ta_out, tb_in, tb_out)) begin
          res <= wmin(res, lift_rd.minw);
        end
        if (!pass) begin
          // second climb: from the other endpoint towards the first
          na     <= nb;
          nb     <= na;
          ta_in  <= tb_in;
          ta_out <= tb_out;
          tb_in  <= ta_in;
          tb_out <= ta_out;
          pass   <= 1'b1;
          lvl    <= LVL_TOP;
          state  <= S_Q_RA;
        end else begin
          state <= S_Q_DONE;
        end
      end
      S_Q_DONE: begin
        if (out_free) begin
          out_valid    <= 1'b1;
          path_minimum <= res;
          state        <= S_IDLE;
        end
      end
      default: begin
        state <= S_IDLE;
      end
    endcase
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      clr_build  <= 1'b0;
      node_count <= FIELD_W'(1);
      out_valid  <= 1'b0;
      time_count <= '0;
      sp         <= '0;
    end
  end

`ifndef SYNTHESIS
  // a result appears only from the query completion state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_Q_DONE)
    else $error("result raised outside query completion");

  // the walk never runs on an empty stack
  assert property (@(posedge clk) disable iff (rst)
    (state == S_W_RD || state == S_W_DEC || state == S_POP) |-> sp != '0)
    else $error("walk step with empty stack");

  // every entered node is left again, so a finished build has an even count
  assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_POP && state == S_IDLE) |-> time_count[0] == 1'b0)
    else $error("build ended with unbalanced entry and exit times");
`endif

endmodule
